[rtl/ucb1_minimax_child_select_macros.svh]
// Assertion macros used by the checker file.
`ifndef UCB1_MINIMAX_CHILD_SELECT_MACROS_SVH
`define UCB1_MINIMAX_CHILD_SELECT_MACROS_SVH

// Checked only while reset is low.
`define UCB1_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define UCB1_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ucb1_mcs_pkg.sv]
`timescale 1ns / 1ps
package ucb1_mcs_pkg;
  localparam int MAX_CHILDREN_DEF = 16;
  localparam int HALF_W = 33;
  localparam int CNT_W = 32;
  localparam int IDX_W = 8;
  localparam int C_W = 16;
  localparam int DVD_W = 48;
  localparam int DIV_STEPS = DVD_W;
  localparam int LN_W = 21;
  localparam int RAD_W = 38;
  localparam int ROOT_W = 20;
  localparam int SQRT_STEPS = 20;
  localparam int TERM_W = 24;
  localparam int SCORE_W = 34;
  localparam logic [C_W-1:0] EXPL_RESET = 16'd410;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic signed [SCORE_W-1:0] ONE_Q16 = 34'sd65536;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 34'sh1FFFFFFFF;
endpackage

[rtl/ucb1_mcs_child_if.sv]
`timescale 1ns / 1ps
interface ucb1_mcs_child_if;
  logic        valid;
  logic        ready;
  logic [32:0] half_reward_sum;
  logic [31:0] visits;
  logic [31:0] parent_visits;
  logic        minimizing;
  logic        explore;
  logic        last_child;
  modport source (output valid, half_reward_sum, visits, parent_visits, minimizing, explore,
                  last_child, input ready);
  modport sink (input valid, half_reward_sum, visits, parent_visits, minimizing, explore,
                last_child, output ready);
endinterface

[rtl/ucb1_mcs_choice_if.sv]
`timescale 1ns / 1ps
interface ucb1_mcs_choice_if;
  logic       valid;
  logic       ready;
  logic [7:0] chosen_index;
  logic       was_unvisited;
  modport source (output valid, chosen_index, was_unvisited, input ready);
  modport sink (input valid, chosen_index, was_unvisited, output ready);
endinterface

[rtl/ucb1_mcs_div.sv]
`timescale 1ns / 1ps
module ucb1_mcs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [47:0] quotient
);
  logic [47:0] dvd;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_next;

  always_comb begin
    shifted = {rem, dvd[47]};
    diff = shifted - {1'b0, dsr};
    ge = shifted >= {1'b0, dsr};
    rem_next = ge ? diff[31:0] : shifted[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      dvd <= {dvd[46:0], ge};
      rem <= rem_next;
      cnt <= cnt + 6'd1;
      if (cnt == 6'(ucb1_mcs_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = dvd;
endmodule

[rtl/ucb1_mcs_ln.sv]
`timescale 1ns / 1ps
module ucb1_mcs_ln (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  output logic        busy,
  output logic [20:0] ln
);
  typedef enum logic [3:0] {
    L_IDLE  = 4'b0001,
    L_NORM  = 4'b0010,
    L_SQ    = 4'b0100,
    L_SCALE = 4'b1000
  } ln_state_t;

  ln_state_t   state;
  logic [31:0] xs;
  logic [4:0]  shifts;
  logic [30:0] y;
  logic [15:0] frac;
  logic [3:0]  k;
  logic [61:0] sq;
  logic [31:0] t;
  logic [4:0]  p;
  logic [36:0] prod;

  always_comb begin
    sq = 62'(y) * 62'(y);
    t = sq[61:30];
    p = 5'd31 - shifts;
    prod = 37'({p, frac}) * 37'(ucb1_mcs_pkg::LN2_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            if (x < 32'd2) begin
              ln <= '0;
            end else begin
              xs <= x;
              shifts <= '0;
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (xs[31]) begin
            y <= xs[31:1];
            frac <= '0;
            k <= '0;
            state <= L_SQ;
          end else begin
            xs <= {xs[30:0], 1'b0};
            shifts <= shifts + 5'd1;
          end
        end
        L_SQ: begin
          y <= t[31] ? t[31:1] : t[30:0];
          frac <= {frac[14:0], t[31]};
          k <= k + 4'd1;
          if (k == 4'd15) begin
            state <= L_SCALE;
          end
        end
        L_SCALE: begin
          ln <= prod[36:16];
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign busy = (state != L_IDLE);
endmodule

[rtl/ucb1_mcs_sqrt.sv]
`timescale 1ns / 1ps
module ucb1_mcs_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [37:0] rad,
  output logic        busy,
  output logic [19:0] root
);
  logic [37:0] v;
  logic [39:0] res;
  logic [39:0] bitv;
  logic [4:0]  cnt;
  logic [39:0] sum;
  logic        ge;

  always_comb begin
    sum = res + bitv;
    ge = {2'b00, v} >= sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      v <= rad;
      res <= '0;
      bitv <= 40'd1 << 38;
      cnt <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (ge) begin
        v <= v - sum[37:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt <= cnt + 5'd1;
      if (cnt == 5'(ucb1_mcs_pkg::SQRT_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign root = res[19:0];
endmodule

[rtl/ucb1_minimax_child_select.sv]
`timescale 1ns / 1ps
// UCB1 child selector for a minimax tree search.
// The child channel carries one child of a parent per item, in arrival order, with the
// parent's visit count, the side to move, the explore bit and a last-child mark. The
// choice channel returns the selected index and whether it was picked for being unvisited.
// The user writes the exploration weight (cfg_we, cfg_wdata) only while the block is idle;
// the block does not enforce this. A visited child is scored with two 48-step bit-serial
// divisions (mean and radicand, the natural log running beside the first) and a 20-step
// square root, holding the block from acceptance to its result and its return to ready.
// An unvisited, skipped or ignored child is not scored. One item is worked at a time.
// The first unvisited child yields a result at once; otherwise the result comes with the
// last child. A result waits in an output register; the block still takes the next item,
// and holds only if a new result is due while the old one has not been taken.
// Reset clears the parent state and restores the exploration weight to 410.
module ucb1_minimax_child_select #(
  parameter int MAX_CHILDREN = ucb1_mcs_pkg::MAX_CHILDREN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_wdata,
  ucb1_mcs_child_if.sink           child,
  ucb1_mcs_choice_if.source        choice
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MEAN  = 7'b0000010,
    S_RAD   = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SCORE = 7'b0100000,
    S_FIN   = 7'b1000000
  } sel_state_t;

  sel_state_t   state;
  logic [15:0]  expl_const;
  logic [7:0]   counter;
  logic [7:0]   best_index;
  logic signed [33:0] best_score;
  logic         done_flag;

  logic [31:0]  visits_q;
  logic         minim;
  logic         expl;
  logic         last;
  logic         unvis;
  logic         active;
  logic [32:0]  mean;
  logic [19:0]  root_q;
  logic [23:0]  term;
  logic signed [33:0] score;

  logic         accept;
  logic         active_in;
  logic         need_in;
  logic         div_start;
  logic [47:0]  div_dividend;
  logic [31:0]  div_divisor;
  logic         div_busy;
  logic [47:0]  quot;
  logic         ln_busy;
  logic [20:0]  ln_val;
  logic         sqrt_start;
  logic         sqrt_busy;
  logic [19:0]  root;
  logic [35:0]  cprod;
  logic [15:0]  c_eff;
  logic signed [34:0] sum35;
  logic signed [33:0] score_next;
  logic signed [33:0] base;
  logic         better;
  logic         unvis_hit;
  logic         has_res;
  logic         stall;
  logic [7:0]   best_index_next;
  logic signed [33:0] best_score_next;
  logic [7:0]   res_index;

  assign accept = child.valid && child.ready;
  assign child.ready = (state == S_IDLE) && !rst;
  assign active_in = !done_flag && (counter < 8'(MAX_CHILDREN));
  assign need_in = active_in && (child.visits != 32'd0);

  always_comb begin
    div_start = 1'b0;
    div_dividend = {child.half_reward_sum, 15'd0};
    div_divisor = child.visits;
    if (accept && need_in) begin
      div_start = 1'b1;
    end
    if (state == S_MEAN && !div_busy && !ln_busy) begin
      div_start = 1'b1;
      div_dividend = {10'd0, ln_val, 17'd0};
      div_divisor = visits_q;
    end
  end

  assign sqrt_start = (state == S_RAD) && !div_busy;

  ucb1_mcs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quotient(quot)
  );

  ucb1_mcs_ln u_ln (
    .clk(clk), .rst(rst), .start(accept && need_in), .x(child.parent_visits),
    .busy(ln_busy), .ln(ln_val)
  );

  ucb1_mcs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .rad(quot[37:0]),
    .busy(sqrt_busy), .root(root)
  );

  always_comb begin
    c_eff = expl ? expl_const : 16'd0;
    cprod = 36'(c_eff) * 36'(root_q);
    sum35 = minim ? ($signed({2'b00, mean}) - $signed({11'd0, term}))
                  : ($signed({2'b00, mean}) + $signed({11'd0, term}));
    if (sum35 > $signed({1'b0, ucb1_mcs_pkg::SCORE_MAX})) begin
      score_next = ucb1_mcs_pkg::SCORE_MAX;
    end else begin
      score_next = sum35[33:0];
    end
    if (counter == 8'd0) begin
      base = minim ? ucb1_mcs_pkg::ONE_Q16 : -ucb1_mcs_pkg::ONE_Q16;
    end else begin
      base = best_score;
    end
    better = minim ? (score < base) : (score > base);
    unvis_hit = active && unvis;
    if (!unvis && better) begin
      best_index_next = counter;
      best_score_next = score;
    end else begin
      best_index_next = (counter == 8'd0) ? 8'd0 : best_index;
      best_score_next = base;
    end
    res_index = active ? best_index_next : best_index;
    has_res = unvis_hit || (last && !done_flag);
    stall = has_res && choice.valid && !choice.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expl_const <= ucb1_mcs_pkg::EXPL_RESET;
    end else if (cfg_we) begin
      expl_const <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      counter <= '0;
      best_index <= '0;
      best_score <= -ucb1_mcs_pkg::ONE_Q16;
      done_flag <= 1'b0;
      choice.valid <= 1'b0;
    end else begin
      if (choice.valid && choice.ready && !(state == S_FIN && has_res)) begin
        choice.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            visits_q <= child.visits;
            minim <= child.minimizing;
            expl <= child.explore;
            last <= child.last_child;
            unvis <= (child.visits == 32'd0);
            active <= active_in;
            state <= need_in ? S_MEAN : S_FIN;
          end
        end
        S_MEAN: begin
          if (!div_busy && !ln_busy) begin
            mean <= (|quot[47:33]) ? '1 : quot[32:0];
            state <= S_RAD;
          end
        end
        S_RAD: begin
          if (!div_busy) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!sqrt_busy) begin
            root_q <= root;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          term <= cprod[35:12];
          state <= S_SCORE;
        end
        S_SCORE: begin
          score <= score_next;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!stall) begin
            if (has_res) begin
              choice.valid <= 1'b1;
              choice.chosen_index <= unvis_hit ? counter : res_index;
              choice.was_unvisited <= unvis_hit;
            end
            if (last) begin
              counter <= '0;
              best_index <= '0;
              best_score <= -ucb1_mcs_pkg::ONE_Q16;
              done_flag <= 1'b0;
            end else if (active) begin
              counter <= counter + 8'd1;
              best_index <= best_index_next;
              best_score <= best_score_next;
              if (unvis) begin
                done_flag <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/ucb1_mcs_checker.sv]
`timescale 1ns / 1ps
`include "ucb1_minimax_child_select_macros.svh"
module ucb1_mcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       child_valid,
  input logic       child_ready,
  input logic       choice_valid,
  input logic       choice_ready,
  input logic [7:0] choice_chosen_index,
  input logic       choice_was_unvisited
);
  `UCB1_ASSERT_RUN(a_choice_hold, (choice_valid && !choice_ready) |=> choice_valid, "choice item dropped while stalled")
  `UCB1_ASSERT_RUN(a_choice_stable, (choice_valid && !choice_ready) |=> ($stable(choice_chosen_index) && $stable(choice_was_unvisited)), "choice item changed while stalled")
  `UCB1_ASSERT_ANY(a_reset_empty, $past(rst) |-> !choice_valid, "choice item present after reset")
  `UCB1_ASSERT_RUN(a_one_at_a_time, (child_valid && child_ready) |=> !child_ready, "second item taken while one is in work")
  `UCB1_ASSERT_RUN(a_result_from_work, $rose(choice_valid) |-> $past(!child_ready), "result appeared without an item in work")
endmodule

bind ucb1_minimax_child_select ucb1_mcs_checker u_ucb1_mcs_checker (
  .clk(clk),
  .rst(rst),
  .child_valid(child.valid),
  .child_ready(child.ready),
  .choice_valid(choice.valid),
  .choice_ready(choice.ready),
  .choice_chosen_index(choice.chosen_index),
  .choice_was_unvisited(choice.was_unvisited)
);

[test/tb_ucb1_minimax_child_select.sv]
`timescale 1ns / 1ps
module tb_ucb1_minimax_child_select;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] chosen_index;
    logic       was_unvisited;
  } choice_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  ucb1_mcs_child_if child ();
  ucb1_mcs_choice_if choice ();

  ucb1_minimax_child_select u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .child(child.sink),
    .choice(choice.source)
  );

  always #5 clk = ~clk;

  choice_t pending_choices[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  logic [15:0] weight_q;
  logic [7:0] kid_count;
  logic [7:0] top_index;
  logic signed [35:0] top_score;
  logic picked_unvisited;

  initial begin
    child.valid = 1'b0;
    child.half_reward_sum = '0;
    child.visits = '0;
    child.parent_visits = '0;
    child.minimizing = 1'b0;
    child.explore = 1'b0;
    child.last_child = 1'b0;
    choice.ready = 1'b0;
  end

  function automatic logic [63:0] log_natural(logic [31:0] x);
    logic [63:0] y;
    logic [15:0] frac;
    int p;
    frac = '0;
    if (x < 2) return 64'd0;
    p = 0;
    while (p < 31 && (x >> (p + 1)) != 0) p++;
    if (p <= 30) y = 64'(x) << (30 - p);
    else y = 64'(x) >> 1;
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return (((64'(p) << 16) | 64'(frac)) * 64'd45426) >> 16;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [35:0] ucb_score(logic [32:0] half, logic [31:0] n,
                                                   logic [31:0] parent, logic minim,
                                                   logic expl);
    logic [63:0] mean;
    logic [63:0] rad;
    logic [63:0] term;
    logic signed [66:0] s;
    mean = (64'(half) << 15) / 64'(n);
    rad = (log_natural(parent) << 17) / 64'(n);
    term = ((expl ? 64'(weight_q) : 64'd0) * root_floor(rad)) >> 12;
    if (mean > 64'h1FFFFFFFF) mean = 64'h1FFFFFFFF;
    s = minim ? $signed({3'b0, mean}) - $signed({3'b0, term})
              : $signed({3'b0, mean}) + $signed({3'b0, term});
    if (s > 67'sh1FFFFFFFF) s = 67'sh1FFFFFFFF;
    if (s < -67'sh200000000) s = -67'sh200000000;
    return 36'(s);
  endfunction

  task automatic predict_choice(logic [32:0] half, logic [31:0] n, logic [31:0] parent,
                                logic minim, logic expl, logic last);
    logic signed [35:0] s;
    logic better;
    choice_t c;
    if (!picked_unvisited && kid_count < ucb1_mcs_pkg::MAX_CHILDREN_DEF) begin
      if (kid_count == 0) begin
        top_score = minim ? 36'sd65536 : -36'sd65536;
        top_index = '0;
      end
      if (n == 0) begin
        c.chosen_index = kid_count;
        c.was_unvisited = 1'b1;
        pending_choices.push_back(c);
        picked_unvisited = 1'b1;
      end else begin
        s = ucb_score(half, n, parent, minim, expl);
        better = minim ? (s < top_score) : (s > top_score);
        if (better) begin
          top_score = s;
          top_index = kid_count;
        end
      end
      kid_count++;
    end
    if (last) begin
      if (!picked_unvisited) begin
        c.chosen_index = top_index;
        c.was_unvisited = 1'b0;
        pending_choices.push_back(c);
      end
      kid_count = '0;
      top_index = '0;
      top_score = -36'sd65536;
      picked_unvisited = 1'b0;
    end
  endtask

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_child(logic [32:0] half, logic [31:0] n, logic [31:0] parent,
                            logic minim, logic expl, logic last);
    int gap;
    gap = random_gap();
    repeat (gap) @(negedge clk);
    child.valid = 1'b1;
    child.half_reward_sum = half;
    child.visits = n;
    child.parent_visits = parent;
    child.minimizing = minim;
    child.explore = expl;
    child.last_child = last;
    @(posedge clk);
    while (!child.ready) @(posedge clk);
    predict_choice(half, n, parent, minim, expl, last);
    @(negedge clk);
    child.valid = 1'b0;
  endtask

  task automatic drain_choices();
    while (pending_choices.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_weight(logic [15:0] value);
    drain_choices();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    weight_q = value;
  endtask

  task automatic send_random_parent(int kids, logic minim, logic expl, int mode);
    logic [31:0] n;
    logic [32:0] half;
    logic [31:0] parent;
    parent = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 5000);
    for (int i = 0; i < kids; i++) begin
      case (mode)
        0: n = $urandom_range(1, 200);
        1: n = $urandom();
        default: n = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 50);
      endcase
      if (n == 0) half = {$urandom(), 1'($urandom())};
      else if ($urandom_range(0, 9) == 0) half = {$urandom(), 1'($urandom())};
      else half = 33'($urandom_range(0, 2)) * 33'(n) / 2 + 33'($urandom_range(0, 1));
      if ($urandom_range(0, 19) == 0) minim = ~minim;
      send_child(half, n, parent, minim, expl, i == kids - 1);
    end
  endtask

  task automatic test_extremes();
    send_child(33'h1FFFFFFFF, 32'd1, 32'hFFFFFFFF, 1'b0, 1'b1, 1'b0);
    send_child(33'd0, 32'hFFFFFFFF, 32'd0, 1'b0, 1'b1, 1'b0);
    send_child(33'd2, 32'd1, 32'd1, 1'b0, 1'b0, 1'b1);
    send_child(33'd0, 32'd1, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0);
    send_child(33'h1FFFFFFFF, 32'hFFFFFFFF, 32'h80000001, 1'b1, 1'b1, 1'b1);
    send_child(33'd5, 32'd5, 32'd10, 1'b0, 1'b1, 1'b0);
    send_child(33'd5, 32'd5, 32'd10, 1'b0, 1'b1, 1'b1);
    send_child(33'd5, 32'd5, 32'd10, 1'b1, 1'b0, 1'b0);
    send_child(33'd5, 32'd5, 32'd10, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_unvisited();
    send_child(33'd4, 32'd3, 32'd9, 1'b0, 1'b1, 1'b0);
    send_child(33'd0, 32'd0, 32'd9, 1'b0, 1'b1, 1'b0);
    send_child(33'd0, 32'd0, 32'd9, 1'b0, 1'b1, 1'b0);
    send_child(33'd4, 32'd3, 32'd9, 1'b0, 1'b1, 1'b1);
    send_child(33'd1, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_too_many();
    for (int i = 0; i < 19; i++)
      send_child(33'(i), 32'd1, 32'd100, 1'b1, 1'b0, i == 18);
  endtask

  task automatic test_random_parents(int items);
    int sent;
    int kids;
    sent = 0;
    while (sent < items) begin
      kids = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
      send_random_parent(kids, 1'($urandom()), ($urandom_range(0, 3) != 0),
                         $urandom_range(0, 2));
      sent += kids;
      if ($urandom_range(0, 49) == 0) drain_choices();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      choice.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      choice.ready <= 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      choice.ready <= 1'b0;
      stall_left = $urandom_range(10, 60);
    end else begin
      choice.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    choice_t want;
    if (!rst && choice.valid && choice.ready) begin
      if (pending_choices.size() == 0) begin
        $error("unexpected result index %0d", choice.chosen_index);
        errors++;
      end else begin
        want = pending_choices.pop_front();
        if (choice.chosen_index !== want.chosen_index) begin
          $error("chosen_index expected %0d actual %0d", want.chosen_index,
                 choice.chosen_index);
          errors++;
        end
        if (choice.was_unvisited !== want.was_unvisited) begin
          $error("was_unvisited expected %0d actual %0d", want.was_unvisited,
                 choice.was_unvisited);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((child.valid && child.ready) || (choice.valid && choice.ready) || rst
        || pending_choices.size() == 0 && !child.valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    weight_q = ucb1_mcs_pkg::EXPL_RESET;
    kid_count = '0;
    top_index = '0;
    top_score = -36'sd65536;
    picked_unvisited = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_unvisited();
    test_too_many();
    write_weight(16'hFFFF);
    test_extremes();
    test_random_parents(300);
    write_weight(16'd0);
    test_random_parents(250);
    write_weight(16'd4096);
    test_random_parents(250);
    write_weight(16'($urandom()));
    test_random_parents(250);
    drain_choices();
    if (errors == 0 && pending_choices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/ucb1_mcs_pkg.sv
rtl/ucb1_mcs_child_if.sv
rtl/ucb1_mcs_choice_if.sv
rtl/ucb1_mcs_div.sv
rtl/ucb1_mcs_ln.sv
rtl/ucb1_mcs_sqrt.sv
rtl/ucb1_minimax_child_select.sv
rtl/ucb1_mcs_checker.sv
test/tb_ucb1_minimax_child_select.sv
